// ===== design/sqm_pkg.sv =====
package sqm_pkg;

  localparam int SEQ_DEPTH = 32;
  localparam int IDX_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(SEQ_DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_APPEND_A = 2'd0,
    KIND_APPEND_B = 2'd1,
    KIND_MERGE    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic emit_empty;
    logic emit_a;
    logic emit_b;
    logic finish;
  } sqm_cmd_t;

  typedef struct packed {
    logic both_empty;
    logic a_more;
    logic b_more;
    logic a_le_b;
    logic one_left;
    logic out_free;
  } sqm_status_t;

endpackage

// ===== design/sqm_ctrl.sv =====
module sqm_ctrl
  import sqm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  kind,
  input  sqm_status_t status,
  output logic        in_ready,
  output sqm_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  kind_t  kind_in;
  logic   accept;
  logic   take_a;

  assign kind_in = kind_t'(kind);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    accept = 1'b0;
    take_a = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = (kind_in != KIND_MERGE) || status.out_free;
        accept = in_valid && in_ready;
        if (accept) begin
          unique case (kind_in)
            KIND_APPEND_A: cmd.push_a = 1'b1;
            KIND_APPEND_B: cmd.push_b = 1'b1;
            KIND_MERGE: begin
              if (status.both_empty) begin
                cmd.emit_empty = 1'b1;
              end else begin
                state_next = ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        if (status.out_free) begin
          take_a = status.a_more && (!status.b_more || status.a_le_b);
          cmd.emit_a = take_a;
          cmd.emit_b = !take_a;
          if (status.one_left) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sqm_dp.sv =====
module sqm_dp
  import sqm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] value,
  input  sqm_cmd_t                 cmd,
  input  logic                     out_ready,
  output sqm_status_t              status,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] merged_value,
  output logic                     last,
  output logic                     empty_res,
  output logic                     dropped
);

  logic signed [DATA_W-1:0] mem_a [SEQ_DEPTH];
  logic signed [DATA_W-1:0] mem_b [SEQ_DEPTH];
  logic signed [DATA_W-1:0] head_a;
  logic signed [DATA_W-1:0] head_b;
  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic [CNT_W-1:0] ia;
  logic [CNT_W-1:0] ib;
  logic [CNT_W-1:0] ia_next;
  logic [CNT_W-1:0] ib_next;
  logic [CNT_W-1:0] ia_inc;
  logic [CNT_W-1:0] ib_inc;
  logic overflow_seen;
  logic full_a;
  logic full_b;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SEQ_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  assign full_a = (count_a == DEPTH_CNT);
  assign full_b = (count_b == DEPTH_CNT);
  assign ia_inc = ia + ONE_CNT;
  assign ib_inc = ib + ONE_CNT;

  always_comb begin
    ia_next = ia;
    ib_next = ib;
    if (cmd.finish) begin
      ia_next = '0;
      ib_next = '0;
    end else if (cmd.emit_a) begin
      ia_next = ia_inc;
    end else if (cmd.emit_b) begin
      ib_next = ib_inc;
    end
  end

  assign status.both_empty = (count_a == '0) && (count_b == '0);
  assign status.a_more = (ia != count_a);
  assign status.b_more = (ib != count_b);
  assign status.a_le_b = (head_a <= head_b);
  assign status.one_left = ((ia_inc == count_a) && (ib == count_b)) ||
                           ((ia == count_a) && (ib_inc == count_b));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.push_a && !full_a) begin
      mem_a[count_a[IDX_W-1:0]] <= value;
    end
    if (cmd.push_b && !full_b) begin
      mem_b[count_b[IDX_W-1:0]] <= value;
    end
    head_a <= mem_a[ia_next[IDX_W-1:0]];
    head_b <= mem_b[ib_next[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
      ia <= '0;
      ib <= '0;
      overflow_seen <= 1'b0;
    end else begin
      ia <= ia_next;
      ib <= ib_next;
      if (cmd.finish || cmd.emit_empty) begin
        count_a <= '0;
        count_b <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (cmd.push_a) begin
          if (full_a) begin
            overflow_seen <= 1'b1;
          end else begin
            count_a <= count_a + ONE_CNT;
          end
        end
        if (cmd.push_b) begin
          if (full_b) begin
            overflow_seen <= 1'b1;
          end else begin
            count_b <= count_b + ONE_CNT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_empty || cmd.emit_a || cmd.emit_b) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      merged_value <= '0;
      last <= 1'b1;
      empty_res <= 1'b1;
      dropped <= overflow_seen;
    end else if (cmd.emit_a || cmd.emit_b) begin
      merged_value <= cmd.emit_a ? head_a : head_b;
      last <= cmd.finish;
      empty_res <= 1'b0;
      dropped <= cmd.finish && overflow_seen;
    end
  end

endmodule

// ===== design/sorted_sequence_merger_top.sv =====
// Two-way stable merge of two sorted sequences of signed 32-bit values.
// The input channel (in_valid, in_ready, kind, value) carries append items
// for sequence A or B and merge items; the output channel (out_valid,
// out_ready, merged_value, last, empty_res, dropped) carries the results.
// Appends are taken while no merge runs, and may follow back to back.
// A merge item, once accepted, puts the controller into its merge state,
// which loads the results into the output register, one result per cycle
// while the receiver takes them, with last on the final one; both
// sequence heads are read ahead from their stores so the merge loop
// emits at that rate. No item is accepted while a merge runs; a merge of
// two empty sequences gives one result marked empty, loaded at the
// accepting edge. Appends to a full sequence are dropped and reported on
// the last result of the next merge.
// When the receiver stalls, the result holds in the output register and
// the merge pauses; outside a merge, appends are accepted while it waits.
// Reset empties both sequences and clears the drop flag.
module sorted_sequence_merger_top
  import sqm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] merged_value,
  output logic                     last,
  output logic                     empty_res,
  output logic                     dropped
);

  sqm_cmd_t    cmd;
  sqm_status_t status;

  sqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sqm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .out_ready    (out_ready),
    .status       (status),
    .out_valid    (out_valid),
    .merged_value (merged_value),
    .last         (last),
    .empty_res    (empty_res),
    .dropped      (dropped)
  );

endmodule

// ===== dv/merge_checker.sv =====
`timescale 1ns / 100ps

module merge_checker
  import sqm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] merged_value,
  input  logic                     last,
  input  logic                     empty_res,
  input  logic                     dropped,
  output int                       errors,
  output int                       pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     last;
    logic                     empty;
    logic                     drop;
  } merge_out_t;

  logic signed [DATA_W-1:0] held_a [SEQ_DEPTH];
  logic signed [DATA_W-1:0] held_b [SEQ_DEPTH];
  int                       fill_a = 0;
  int                       fill_b = 0;
  bit                       lost_append = 1'b0;
  merge_out_t               merged_q [$];
  int                       err_count = 0;

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) begin
      $display("merge_checker: %0t: %s", $realtime, msg);
    end
  endtask

  task automatic predict_item(input kind_t k, input logic signed [DATA_W-1:0] v);
    int         ia;
    int         ib;
    merge_out_t r;
    case (k)
      KIND_APPEND_A: begin
        if (fill_a < SEQ_DEPTH) begin
          held_a[fill_a] = v;
          fill_a++;
        end else begin
          lost_append = 1'b1;
        end
      end
      KIND_APPEND_B: begin
        if (fill_b < SEQ_DEPTH) begin
          held_b[fill_b] = v;
          fill_b++;
        end else begin
          lost_append = 1'b1;
        end
      end
      KIND_MERGE: begin
        if (fill_a + fill_b == 0) begin
          r.val = '0;
          r.last = 1'b1;
          r.empty = 1'b1;
          r.drop = lost_append;
          merged_q.push_back(r);
        end else begin
          ia = 0;
          ib = 0;
          while (ia < fill_a || ib < fill_b) begin
            // Ties go to sequence A so that the merge stays stable.
            if (ia < fill_a && (ib >= fill_b || held_a[ia] <= held_b[ib])) begin
              r.val = held_a[ia];
              ia++;
            end else begin
              r.val = held_b[ib];
              ib++;
            end
            r.last = (ia + ib == fill_a + fill_b);
            r.empty = 1'b0;
            r.drop = r.last & lost_append;
            merged_q.push_back(r);
          end
        end
        fill_a = 0;
        fill_b = 0;
        lost_append = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result();
    merge_out_t want;
    if (merged_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", merged_value));
      return;
    end
    want = merged_q.pop_front();
    if (merged_value !== want.val) begin
      report_mismatch($sformatf("merged_value got %0d expected %0d", merged_value, want.val));
    end
    if (last !== want.last) begin
      report_mismatch($sformatf("last got %b expected %b", last, want.last));
    end
    if (empty_res !== want.empty) begin
      report_mismatch($sformatf("empty_res got %b expected %b", empty_res, want.empty));
    end
    if (dropped !== want.drop) begin
      report_mismatch($sformatf("dropped got %b expected %b", dropped, want.drop));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill_a = 0;
      fill_b = 0;
      lost_append = 1'b0;
      merged_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_result();
      end
      if (in_valid && in_ready) begin
        predict_item(kind_t'(kind), value);
      end
    end
    pending <= merged_q.size();
    errors <= err_count;
  end

endmodule

// ===== dv/tb_sorted_sequence_merger_top.sv =====
`timescale 1ns / 100ps

module tb_sorted_sequence_merger_top
  import sqm_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEM_TARGET = 330;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               kind = KIND_APPEND_A;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last;
  logic                     empty_res;
  logic                     dropped;
  int                       errors;
  int                       pending;
  bit                       idle_on = 1'b1;
  int                       sent_items = 0;
  int                       cycle_count = 0;

  always #5 clk = ~clk;

  sorted_sequence_merger_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .merged_value (merged_value),
    .last         (last),
    .empty_res    (empty_res),
    .dropped      (dropped)
  );

  merge_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .merged_value (merged_value),
    .last         (last),
    .empty_res    (empty_res),
    .dropped      (dropped),
    .errors       (errors),
    .pending      (pending)
  );

  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** sorted_sequence_merger_top: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input kind_t k, input logic signed [DATA_W-1:0] v);
    while (idle_on && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (k != KIND_NONE) begin
      sent_items++;
    end
  endtask

  // One batch of appends to both sequences, interleaved at random with occasional KIND_NONE items, closed by a merge.
  task automatic run_batch();
    int                       na;
    int                       nb;
    int                       ia;
    int                       ib;
    int                       pick;
    bit                       ties;
    bit                       broken;
    logic signed [DATA_W-1:0] va;
    logic signed [DATA_W-1:0] vb;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      na = $urandom_range(0, 6);
      nb = $urandom_range(0, 6);
    end else if (pick < 90) begin
      na = $urandom_range(0, SEQ_DEPTH);
      nb = $urandom_range(0, SEQ_DEPTH);
    end else begin
      na = $urandom_range(SEQ_DEPTH - 4, SEQ_DEPTH + 4);
      nb = $urandom_range(SEQ_DEPTH - 4, SEQ_DEPTH + 4);
    end
    ties = ($urandom_range(0, 3) == 0);
    broken = ($urandom_range(0, 9) == 0);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      va = {1'b1, {(DATA_W - 1){1'b0}}};
    end else if (pick == 1) begin
      va = {1'b0, {(DATA_W - 1){1'b1}}} - 3;
      ties = 1'b1;
    end else begin
      va = $urandom;
    end
    vb = ties ? va : $urandom;
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 99) < 4) begin
        send_item(KIND_NONE, $urandom);
      end
      if (ia < na && (ib >= nb || $urandom_range(0, 1) == 0)) begin
        send_item(KIND_APPEND_A, va);
        ia++;
        if (broken) begin
          va = $urandom;
        end else begin
          va = va + (ties ? $urandom_range(0, 1) : $urandom_range(0, 32'h00ff_ffff));
        end
      end else begin
        send_item(KIND_APPEND_B, vb);
        ib++;
        if (broken) begin
          vb = $urandom;
        end else begin
          vb = vb + (ties ? $urandom_range(0, 1) : $urandom_range(0, 32'h00ff_ffff));
        end
      end
    end
    send_item(KIND_MERGE, $urandom);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(KIND_MERGE, 32'sd0);
    send_item(KIND_APPEND_A, {1'b1, {(DATA_W - 1){1'b0}}});
    send_item(KIND_APPEND_B, -32'sd1);
    send_item(KIND_APPEND_A, -32'sd1);
    send_item(KIND_APPEND_A, 32'sd0);
    send_item(KIND_NONE, -32'sd1);
    send_item(KIND_APPEND_B, {1'b0, {(DATA_W - 1){1'b1}}});
    send_item(KIND_MERGE, {1'b0, {(DATA_W - 1){1'b1}}});
    send_item(KIND_APPEND_A, 32'sd7);
    send_item(KIND_APPEND_A, 32'sd8);
    send_item(KIND_MERGE, -32'sd1);
    send_item(KIND_APPEND_B, 32'sd5);
    send_item(KIND_MERGE, 32'sd0);
    send_item(KIND_APPEND_A, 32'sd10);
    send_item(KIND_APPEND_A, 32'sd3);
    send_item(KIND_APPEND_B, 32'sd5);
    send_item(KIND_APPEND_B, 32'sd3);
    send_item(KIND_MERGE, 32'sd0);

    while (sent_items < ITEM_TARGET) begin
      idle_on <= !(sent_items >= 140 && sent_items < 220);
      run_batch();
    end
    in_valid <= 1'b0;
    idle_on <= 1'b1;

    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("** sorted_sequence_merger_top: PASSED **");
    end else begin
      $display("** sorted_sequence_merger_top: FAILED **");
    end
    $finish;
  end

endmodule
